@@ design/priority_command_mux_with_timeout_defines.svh @@
// assertion helpers for the command mux checker
`ifndef PRIORITY_COMMAND_MUX_WITH_TIMEOUT_DEFINES_SVH
`define PRIORITY_COMMAND_MUX_WITH_TIMEOUT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PCMUX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PCMUX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pcmux_pkg.sv @@
package pcmux_pkg;

  localparam int MAX_SRC         = 4;
  localparam int AXES            = 6;
  localparam int TO_W            = 16;
  localparam int PR_W            = 8;
  localparam int VEL_W           = 32;
  localparam int STAMP_W         = 32;
  localparam int ROW_W           = AXES * VEL_W + STAMP_W;
  localparam int CODE_W          = 3;
  localparam int SRC_IN_W        = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int NUM_SOURCES_DEF = 4;
  localparam int AGE_BITS_DEF    = 16;

  // selection code for "no source active"
  localparam logic [CODE_W-1:0] IDLE_CODE = 3'd4;

  // first priority register in the config map
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO_BASE = 3'd4;

  localparam logic [TO_W-1:0] TO_RESET [MAX_SRC] = '{16'd80, 16'd200, 16'd200, 16'd200};
  localparam logic [PR_W-1:0] PR_RESET [MAX_SRC] = '{8'd100, 8'd10, 8'd10, 8'd10};

  typedef enum logic [1:0] {
    OP_MSG  = 2'd0,
    OP_TICK = 2'd1,
    OP_PUB  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic store;
    logic tick;
    logic scan_clr;
    logic scan_step;
    logic rd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic src_ok;
    logic scan_last;
  } sts_t;

endpackage

@@ design/pcmux_ctrl.sv @@
module pcmux_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  pcmux_pkg::sts_t sts,
  output pcmux_pkg::cmd_t cmd,
  output logic            busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.op)
          pcmux_pkg::OP_MSG: begin
            cmd.store = sts.src_ok;
            state_nxt = ST_IDLE;
          end
          pcmux_pkg::OP_TICK: begin
            cmd.tick  = 1'b1;
            state_nxt = ST_IDLE;
          end
          pcmux_pkg::OP_PUB: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = ST_SCAN;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

@@ design/pcmux_dp.sv @@
module pcmux_dp #(
  parameter int NUM_SOURCES = pcmux_pkg::NUM_SOURCES_DEF,
  parameter int AGE_BITS    = pcmux_pkg::AGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pcmux_pkg::cmd_t                      cmd,
  output pcmux_pkg::sts_t                      sts,
  input  logic [1:0]                           in_op,
  input  logic [pcmux_pkg::SRC_IN_W-1:0]       in_source,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_linear_x,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_linear_y,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_linear_z,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_angular_x,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_angular_y,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_angular_z,
  input  logic [pcmux_pkg::STAMP_W-1:0]        in_stamp,
  input  logic                                 cfg_we,
  input  logic [pcmux_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcmux_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                 out_strobe,
  output logic                                 out_active_valid,
  output logic [pcmux_pkg::SRC_IN_W-1:0]       out_active_source,
  output logic                                 out_active_changed,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_linear_x,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_linear_y,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_linear_z,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_angular_x,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_angular_y,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_angular_z,
  output logic [pcmux_pkg::STAMP_W-1:0]        out_stamp
);

  localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CMP_W = (AGE_BITS > pcmux_pkg::TO_W) ? AGE_BITS : pcmux_pkg::TO_W;
  localparam int VW    = pcmux_pkg::VEL_W;
  localparam int RW    = pcmux_pkg::ROW_W;

  // latched transaction
  pcmux_pkg::op_t                   op_r;
  logic [pcmux_pkg::SRC_IN_W-1:0]   src_r;
  logic [RW-1:0]                    row_r;

  // config registers
  logic [pcmux_pkg::TO_W-1:0]       to_r [pcmux_pkg::MAX_SRC];
  logic [pcmux_pkg::PR_W-1:0]       pr_r [pcmux_pkg::MAX_SRC];

  // per-source state
  logic [RW-1:0]                    mem [NUM_SOURCES];
  logic                             has_r [NUM_SOURCES];
  logic [AGE_BITS-1:0]              age_r [NUM_SOURCES];

  // scan state
  logic [SRC_W-1:0]                 idx_r;
  logic [SRC_W-1:0]                 best_r;
  logic [pcmux_pkg::PR_W-1:0]       best_pr_r;
  logic                             found_r;
  logic [RW-1:0]                    rd_r;
  logic [pcmux_pkg::CODE_W-1:0]     last_active_r;

  logic                             fresh;
  logic                             better;
  logic [pcmux_pkg::CODE_W-1:0]     code;

  assign sts.op        = op_r;
  assign sts.src_ok    = ({1'b0, src_r} < (pcmux_pkg::SRC_IN_W + 1)'(NUM_SOURCES));
  assign sts.scan_last = (idx_r == SRC_W'(NUM_SOURCES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= pcmux_pkg::op_t'(in_op);
      src_r <= in_source;
      row_r <= {in_stamp, in_angular_z, in_angular_y, in_angular_x,
                in_linear_z, in_linear_y, in_linear_x};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pcmux_pkg::MAX_SRC; i++) begin
        to_r[i] <= pcmux_pkg::TO_RESET[i];
        pr_r[i] <= pcmux_pkg::PR_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index < pcmux_pkg::CFG_PRIO_BASE) begin
        to_r[cfg_index[1:0]] <= cfg_data;
      end else begin
        pr_r[2'(cfg_index - pcmux_pkg::CFG_PRIO_BASE)] <= cfg_data[pcmux_pkg::PR_W-1:0];
      end
    end
  end

  // command memory: one row per source, undefined until written
  always_ff @(posedge clk) begin
    if (cmd.store) mem[src_r[SRC_W-1:0]] <= row_r;
    if (cmd.rd)    rd_r <= mem[best_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        has_r[i] <= 1'b0;
        age_r[i] <= '0;
      end
    end else if (cmd.store) begin
      has_r[src_r[SRC_W-1:0]] <= 1'b1;
      age_r[src_r[SRC_W-1:0]] <= '0;
    end else if (cmd.tick) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (age_r[i] != {AGE_BITS{1'b1}}) age_r[i] <= age_r[i] + AGE_BITS'(1);
      end
    end
  end

  // one source per cycle
  assign fresh  = has_r[idx_r] && (CMP_W'(age_r[idx_r]) <= CMP_W'(to_r[idx_r]));
  assign better = fresh && (!found_r || (pr_r[idx_r] > best_pr_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + SRC_W'(1);
      if (better) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      best_r    <= '0;
      best_pr_r <= '0;
    end else if (cmd.scan_step && better) begin
      best_r    <= idx_r;
      best_pr_r <= pr_r[idx_r];
    end
  end

  assign code = found_r ? pcmux_pkg::CODE_W'(best_r) : pcmux_pkg::IDLE_CODE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_active_r <= pcmux_pkg::IDLE_CODE;
      out_strobe    <= 1'b0;
    end else begin
      out_strobe <= cmd.emit;
      if (cmd.emit) last_active_r <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_active_valid   <= found_r;
      out_active_source  <= found_r ? pcmux_pkg::SRC_IN_W'(best_r) : '0;
      out_active_changed <= (code != last_active_r);
      out_linear_x       <= found_r ? rd_r[0*VW +: VW] : '0;
      out_linear_y       <= found_r ? rd_r[1*VW +: VW] : '0;
      out_linear_z       <= found_r ? rd_r[2*VW +: VW] : '0;
      out_angular_x      <= found_r ? rd_r[3*VW +: VW] : '0;
      out_angular_y      <= found_r ? rd_r[4*VW +: VW] : '0;
      out_angular_z      <= found_r ? rd_r[5*VW +: VW] : '0;
      out_stamp          <= found_r ? rd_r[6*VW +: pcmux_pkg::STAMP_W] : '0;
    end
  end

endmodule

@@ design/priority_command_mux_with_timeout.sv @@
// message, tick and unused ops: busy only while the op is decoded, then back to idle
// publish: busy through decode, one scan step per source, memory read and
// output register
// result strobe in the first cycle with busy low
// one transaction at a time; the receiver cannot stall, each result shows for one cycle
// synchronous active-low reset clears flags, ages, last selection and restores config
module priority_command_mux_with_timeout #(
  parameter int NUM_SOURCES = pcmux_pkg::NUM_SOURCES_DEF,
  parameter int AGE_BITS    = pcmux_pkg::AGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_op,
  input  logic [pcmux_pkg::SRC_IN_W-1:0]       in_source,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_linear_x,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_linear_y,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_linear_z,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_angular_x,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_angular_y,
  input  logic signed [pcmux_pkg::VEL_W-1:0]   in_angular_z,
  input  logic [pcmux_pkg::STAMP_W-1:0]        in_stamp,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcmux_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcmux_pkg::CFG_DATA_W-1:0]     cfg_data,
  // result channel
  output logic                                 out_strobe,
  output logic                                 out_active_valid,
  output logic [pcmux_pkg::SRC_IN_W-1:0]       out_active_source,
  output logic                                 out_active_changed,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_linear_x,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_linear_y,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_linear_z,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_angular_x,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_angular_y,
  output logic signed [pcmux_pkg::VEL_W-1:0]   out_angular_z,
  output logic [pcmux_pkg::STAMP_W-1:0]        out_stamp
);

  pcmux_pkg::cmd_t cmd;
  pcmux_pkg::sts_t sts;

  // config writes land directly in the config registers, so the port never pushes back
  assign cfg_ready = 1'b1;

  // sequencer: decode the latched op, walk the sources, read, emit
  pcmux_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: config registers, command memory, ages, the priority scan
  // and the output register
  pcmux_dp #(
    .NUM_SOURCES (NUM_SOURCES),
    .AGE_BITS    (AGE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_source          (in_source),
    .in_linear_x        (in_linear_x),
    .in_linear_y        (in_linear_y),
    .in_linear_z        (in_linear_z),
    .in_angular_x       (in_angular_x),
    .in_angular_y       (in_angular_y),
    .in_angular_z       (in_angular_z),
    .in_stamp           (in_stamp),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_active_valid   (out_active_valid),
    .out_active_source  (out_active_source),
    .out_active_changed (out_active_changed),
    .out_linear_x       (out_linear_x),
    .out_linear_y       (out_linear_y),
    .out_linear_z       (out_linear_z),
    .out_angular_x      (out_angular_x),
    .out_angular_y      (out_angular_y),
    .out_angular_z      (out_angular_z),
    .out_stamp          (out_stamp)
  );

endmodule

@@ design/pcmux_checker.sv @@
`include "priority_command_mux_with_timeout_defines.svh"

module pcmux_checker #(
  parameter int NUM_SOURCES = pcmux_pkg::NUM_SOURCES_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 out_strobe,
  input logic                                 out_active_valid,
  input logic [pcmux_pkg::SRC_IN_W-1:0]       out_active_source,
  input logic signed [pcmux_pkg::VEL_W-1:0]   out_linear_x,
  input logic signed [pcmux_pkg::VEL_W-1:0]   out_angular_z,
  input logic [pcmux_pkg::STAMP_W-1:0]        out_stamp
);

  // an idle result carries no command
  `PCMUX_ASSERT_SAME(a_idle_zero, out_strobe && !out_active_valid, out_active_source == '0 && out_linear_x == '0 && out_angular_z == '0 && out_stamp == '0, "idle result with nonzero payload")

  // a selected source is one that exists
  `PCMUX_ASSERT_SAME(a_src_range, out_strobe && out_active_valid, ({1'b0, out_active_source} < (pcmux_pkg::SRC_IN_W + 1)'(NUM_SOURCES)), "selected source out of range")

  // a result only follows a transaction in flight
  `PCMUX_ASSERT_SAME(a_strobe_after_busy, out_strobe, $past(busy), "result strobe without a transaction in flight")

  // results never come back to back
  `PCMUX_ASSERT_NEXT(a_strobe_pulse, out_strobe, !out_strobe, "result strobe longer than one cycle")

  // an accepted transaction keeps the block busy
  `PCMUX_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy did not rise after a transaction")

endmodule

bind priority_command_mux_with_timeout pcmux_checker #(
  .NUM_SOURCES (NUM_SOURCES)
) u_pcmux_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_strobe        (out_strobe),
  .out_active_valid  (out_active_valid),
  .out_active_source (out_active_source),
  .out_linear_x      (out_linear_x),
  .out_angular_z     (out_angular_z),
  .out_stamp         (out_stamp)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // settle time after the last result before a register write or the end:
  // long enough for a message, a tick or a full publish scan and its strobe
  localparam int SETTLE_CYCLES = 12;
  // cycles without any transaction before the run is declared hung
  localparam int QUIET_LIMIT   = 2000;
  localparam int NUM_REGS      = 2 * pcmux_pkg::MAX_SRC;

  typedef struct packed {
    pcmux_pkg::op_t                                          op;
    logic [pcmux_pkg::SRC_IN_W-1:0]                          src;
    logic [pcmux_pkg::AXES-1:0][pcmux_pkg::VEL_W-1:0]        vel;
    logic [pcmux_pkg::STAMP_W-1:0]                           stamp;
  } command_t;

  typedef struct packed {
    logic                                                    valid;
    logic [pcmux_pkg::SRC_IN_W-1:0]                          src;
    logic                                                    changed;
    logic [pcmux_pkg::AXES-1:0][pcmux_pkg::VEL_W-1:0]        vel;
    logic [pcmux_pkg::STAMP_W-1:0]                           stamp;
  } pick_t;

  typedef logic [NUM_REGS-1:0][pcmux_pkg::CFG_DATA_W-1:0] reg_image_t;

  // dut stimulus, all known from time zero
  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   start = 1'b0;
  logic [1:0]                             in_op = pcmux_pkg::OP_NONE;
  logic [pcmux_pkg::SRC_IN_W-1:0]         in_source = '0;
  logic signed [pcmux_pkg::VEL_W-1:0]     in_linear_x = '0;
  logic signed [pcmux_pkg::VEL_W-1:0]     in_linear_y = '0;
  logic signed [pcmux_pkg::VEL_W-1:0]     in_linear_z = '0;
  logic signed [pcmux_pkg::VEL_W-1:0]     in_angular_x = '0;
  logic signed [pcmux_pkg::VEL_W-1:0]     in_angular_y = '0;
  logic signed [pcmux_pkg::VEL_W-1:0]     in_angular_z = '0;
  logic [pcmux_pkg::STAMP_W-1:0]          in_stamp = '0;
  logic                                   cfg_valid = 1'b0;
  logic [pcmux_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [pcmux_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

  logic                                   busy;
  logic                                   cfg_ready;
  logic                                   out_strobe;
  logic                                   out_active_valid;
  logic [pcmux_pkg::SRC_IN_W-1:0]         out_active_source;
  logic                                   out_active_changed;
  logic signed [pcmux_pkg::VEL_W-1:0]     out_linear_x;
  logic signed [pcmux_pkg::VEL_W-1:0]     out_linear_y;
  logic signed [pcmux_pkg::VEL_W-1:0]     out_linear_z;
  logic signed [pcmux_pkg::VEL_W-1:0]     out_angular_x;
  logic signed [pcmux_pkg::VEL_W-1:0]     out_angular_y;
  logic signed [pcmux_pkg::VEL_W-1:0]     out_angular_z;
  logic [pcmux_pkg::STAMP_W-1:0]          out_stamp;

  // predictor copy of the mux state, starts at reset values
  logic [pcmux_pkg::TO_W-1:0]      fresh_limit [pcmux_pkg::MAX_SRC] = pcmux_pkg::TO_RESET;
  logic [pcmux_pkg::PR_W-1:0]      rank [pcmux_pkg::MAX_SRC] = pcmux_pkg::PR_RESET;
  logic [pcmux_pkg::AXES-1:0][pcmux_pkg::VEL_W-1:0] cmd_vel [pcmux_pkg::MAX_SRC];
  logic [pcmux_pkg::STAMP_W-1:0]   cmd_stamp [pcmux_pkg::MAX_SRC];
  bit                              cmd_held [pcmux_pkg::MAX_SRC] = '{default: 1'b0};
  logic [pcmux_pkg::AGE_BITS_DEF-1:0] tick_count [pcmux_pkg::MAX_SRC] = '{default: '0};
  logic [pcmux_pkg::CODE_W-1:0]    last_pick = pcmux_pkg::IDLE_CODE;

  pick_t                           expected_picks [$];
  int                              fail_count = 0;
  int                              quiet_cycles = 0;
  int                              sender_idle_pct = 0;

  priority_command_mux_with_timeout dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_source          (in_source),
    .in_linear_x        (in_linear_x),
    .in_linear_y        (in_linear_y),
    .in_linear_z        (in_linear_z),
    .in_angular_x       (in_angular_x),
    .in_angular_y       (in_angular_y),
    .in_angular_z       (in_angular_z),
    .in_stamp           (in_stamp),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_strobe         (out_strobe),
    .out_active_valid   (out_active_valid),
    .out_active_source  (out_active_source),
    .out_active_changed (out_active_changed),
    .out_linear_x       (out_linear_x),
    .out_linear_y       (out_linear_y),
    .out_linear_z       (out_linear_z),
    .out_angular_x      (out_angular_x),
    .out_angular_y      (out_angular_y),
    .out_angular_z      (out_angular_z),
    .out_stamp          (out_stamp)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // predictor: update state for one accepted transaction, queue the publish result
  function automatic void predict_pick(command_t c);
    logic                           found;
    logic [pcmux_pkg::SRC_IN_W-1:0] best;
    logic [pcmux_pkg::CODE_W-1:0]   code;
    pick_t                          p;
    found = 1'b0;
    best  = '0;
    p     = '0;
    case (c.op)
      pcmux_pkg::OP_MSG: begin
        cmd_vel[c.src]    = c.vel;
        cmd_stamp[c.src]  = c.stamp;
        cmd_held[c.src]   = 1'b1;
        tick_count[c.src] = '0;
      end
      pcmux_pkg::OP_TICK: begin
        // ages stop at all ones
        for (int s = 0; s < pcmux_pkg::MAX_SRC; s++) begin
          if (tick_count[s] != '1) tick_count[s] = tick_count[s] + 1'b1;
        end
      end
      pcmux_pkg::OP_PUB: begin
        // strictly greater rank replaces, so a tie keeps the lower index
        for (int s = 0; s < pcmux_pkg::MAX_SRC; s++) begin
          if (cmd_held[s] && tick_count[s] <= fresh_limit[s] &&
              (!found || rank[s] > rank[best])) begin
            best  = pcmux_pkg::SRC_IN_W'(s);
            found = 1'b1;
          end
        end
        code      = found ? pcmux_pkg::CODE_W'(best) : pcmux_pkg::IDLE_CODE;
        p.valid   = found;
        p.src     = best;
        p.changed = (code != last_pick);
        if (found) begin
          p.vel   = cmd_vel[best];
          p.stamp = cmd_stamp[best];
        end
        last_pick = code;
        expected_picks.insert(expected_picks.size(), p);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [pcmux_pkg::VEL_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic command_t make_command(pcmux_pkg::op_t op,
                                            logic [pcmux_pkg::SRC_IN_W-1:0] src);
    command_t c;
    c.op  = op;
    c.src = src;
    for (int k = 0; k < pcmux_pkg::AXES; k++) c.vel[k] = rand_word();
    c.stamp = $urandom;
    return c;
  endfunction

  // one transaction on the command channel; start stays high into the next call
  // unless the sender decides to idle
  task automatic issue_command(command_t c);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start        <= 1'b1;
    in_op        <= c.op;
    in_source    <= c.src;
    in_linear_x  <= c.vel[0];
    in_linear_y  <= c.vel[1];
    in_linear_z  <= c.vel[2];
    in_angular_x <= c.vel[3];
    in_angular_y <= c.vel[4];
    in_angular_z <= c.vel[5];
    in_stamp     <= c.stamp;
    do @(posedge clk); while (busy);
    predict_pick(c);
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) begin
      issue_command(make_command(pcmux_pkg::OP_TICK, pcmux_pkg::SRC_IN_W'($urandom)));
    end
  endtask

  // drop start, let every pending publish come back, then let the block settle
  task automatic wait_all_results();
    start <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes every register in index order, only called while the block is idle
  task automatic load_registers(reg_image_t words);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= pcmux_pkg::CFG_IDX_W'(i);
      cfg_data  <= words[i];
      do @(posedge clk); while (!cfg_ready);
      if (i < pcmux_pkg::CFG_PRIO_BASE) fresh_limit[i] = words[i];
      else rank[i - pcmux_pkg::CFG_PRIO_BASE] = words[i][pcmux_pkg::PR_W-1:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly short timeouts so ages cross them, sometimes zero or the maximum;
  // ranks from four levels to force ties, junk in the unused upper data bits
  function automatic reg_image_t random_registers();
    reg_image_t w;
    int         r;
    for (int s = 0; s < pcmux_pkg::MAX_SRC; s++) begin
      r = $urandom_range(15);
      w[s] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff :
             pcmux_pkg::CFG_DATA_W'($urandom_range(1, 12));
      w[pcmux_pkg::CFG_PRIO_BASE + s] = {8'($urandom), 8'($urandom_range(3) * 85)};
    end
    return w;
  endfunction

  // publish straight out of reset: idle with no change, unused op ignored
  task automatic test_first_publish();
    sender_idle_pct = 0;
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));
    issue_command(make_command(pcmux_pkg::OP_NONE, 2'd3));
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd1));
    wait_all_results();
  endtask

  // reset timeouts and ranks, then ages cross each limit
  task automatic test_age_timeouts();
    reg_image_t w;
    sender_idle_pct = 0;
    issue_command(make_command(pcmux_pkg::OP_MSG, 2'd0));
    issue_command(make_command(pcmux_pkg::OP_MSG, 2'd1));
    send_ticks(80);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));   // source 0 right at its limit
    send_ticks(1);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));   // source 0 stale, source 1 takes over
    send_ticks(119);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));
    send_ticks(1);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));   // everything stale, back to idle
    wait_all_results();
    // timeouts at the top of the range bring stale sources back
    w = {16'd10, 16'd10, 16'd10, 16'd100, 16'd200, 16'd200, 16'hfffe, 16'hffff};
    load_registers(w);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));
    wait_all_results();
    w[0] = 16'hfffe;
    load_registers(w);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));
    send_ticks(2);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));
    wait_all_results();
  endtask

  // zero timeout, rank ties, rank extremes, field extremes
  task automatic test_corner_cases();
    reg_image_t w;
    command_t   c;
    sender_idle_pct = 0;
    // ranks 0, 200, 255, 200 with garbage above bit 7
    w = {16'h55c8, 16'hffff, 16'h00c8, 16'h0000, 16'hffff, 16'h0000, 16'h0003, 16'h0001};
    load_registers(w);
    c = make_command(pcmux_pkg::OP_MSG, 2'd3);
    c.vel = {pcmux_pkg::AXES{32'h7fff_ffff}};
    c.stamp = '1;
    issue_command(c);
    c = make_command(pcmux_pkg::OP_MSG, 2'd1);
    c.vel = {pcmux_pkg::AXES{32'h8000_0000}};
    c.stamp = '0;
    issue_command(c);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));   // tie between 1 and 3
    c = make_command(pcmux_pkg::OP_MSG, 2'd2);
    c.vel = {32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff};
    issue_command(c);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));   // zero timeout, fresh at age 0
    send_ticks(1);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));   // zero timeout expired
    issue_command(make_command(pcmux_pkg::OP_MSG, 2'd0));
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));   // rank 0 loses
    send_ticks(3);
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd0));   // only the max timeout survives
    issue_command(make_command(pcmux_pkg::OP_NONE, 2'd2));
    issue_command(make_command(pcmux_pkg::OP_PUB, 2'd3));
    wait_all_results();
  endtask

  // random traffic in two register settings at a given sender idle rate
  task automatic test_random_traffic(int idle_pct, int items);
    int sel;
    int n;
    int burst;
    for (int part = 0; part < 2; part++) begin
      wait_all_results();
      load_registers(random_registers());
      sender_idle_pct = idle_pct;
      n = 0;
      while (n < items / 2) begin
        sel = $urandom_range(99);
        if (sel < 3) begin
          // ignored by the block, not counted
          issue_command(make_command(pcmux_pkg::OP_NONE, pcmux_pkg::SRC_IN_W'($urandom)));
        end else if (sel < 38) begin
          issue_command(make_command(pcmux_pkg::OP_MSG, pcmux_pkg::SRC_IN_W'($urandom)));
          n++;
        end else if (sel < 66) begin
          send_ticks(1);
          n++;
        end else if (sel < 69) begin
          // long silence so sources with short timeouts go stale
          burst = $urandom_range(4, 20);
          send_ticks(burst);
          n += burst;
        end else begin
          issue_command(make_command(pcmux_pkg::OP_PUB, pcmux_pkg::SRC_IN_W'($urandom)));
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_first_publish();
    test_age_timeouts();
    test_corner_cases();
    test_random_traffic(12, 560);
    test_random_traffic(56, 560);
    test_random_traffic(0, 560);
    wait_all_results();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // every strobe is one result transaction, matched against the oldest prediction
  always @(posedge clk) begin : pick_check
    pick_t want;
    if (rst_n && out_strobe) begin
      if (expected_picks.size() == 0) begin
        $display("%0t unexpected result: expected none, actual source %0d valid %0b",
                 $time, out_active_source, out_active_valid);
        fail_count++;
      end else begin
        want = expected_picks.pop_front();
        check_field("active_valid", want.valid, out_active_valid);
        check_field("active_source", want.src, out_active_source);
        check_field("active_changed", want.changed, out_active_changed);
        check_field("linear_x", want.vel[0], out_linear_x);
        check_field("linear_y", want.vel[1], out_linear_y);
        check_field("linear_z", want.vel[2], out_linear_z);
        check_field("angular_x", want.vel[3], out_angular_x);
        check_field("angular_y", want.vel[4], out_angular_y);
        check_field("angular_z", want.vel[5], out_angular_z);
        check_field("stamp", want.stamp, out_stamp);
      end
    end
  end

  // hang detector: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
